// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication: whenever ante holds, cons holds in that cycle.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== src/lal_pkg.sv =====
package lal_pkg;

	// Fixed widths of the word fields.
	localparam int VALUE_W = 32;
	localparam int POS_W   = 7;
	localparam int COUNT_W = 7;

	// This value is never stored in the list.
	localparam logic signed [VALUE_W-1:0] RESERVED_VALUE = 32'sh7FFF_FFFF;

	typedef enum logic {
		FUNC_INSERT = 1'b0,
		FUNC_SEARCH = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_BAD_POS  = 2'd1,
		STAT_FULL     = 2'd2,
		STAT_RESERVED = 2'd3
	} status_t;

endpackage

// ===== src/lal_store.sv =====
// Simple dual-port list storage: one write and one registered read per cycle.
module lal_store #(
	parameter int DEPTH = 127,
	parameter int AW    = 7
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [AW-1:0]                     waddr,
	input  logic signed [lal_pkg::VALUE_W-1:0] wdata,
	input  logic                              re,
	input  logic [AW-1:0]                     raddr,
	output logic signed [lal_pkg::VALUE_W-1:0] rdata
);

	logic signed [lal_pkg::VALUE_W-1:0] mem [DEPTH];
	logic signed [lal_pkg::VALUE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/lal_seq.sv =====
`include "assert_macros.svh"

// Operation sequencer: decodes a command, walks the store for a shift or a scan,
// and keeps the list length and the result registers.
module lal_seq #(
	parameter int SLOTS = 127,
	parameter int AW    = 7,
	parameter int LW    = 7
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               func,
	input  logic signed [lal_pkg::VALUE_W-1:0] value,
	input  logic [lal_pkg::POS_W-1:0]          position,
	output logic                               done,
	output logic [1:0]                         status,
	output logic                               found,
	output logic [lal_pkg::COUNT_W-1:0]        count,
	output logic                               mem_we,
	output logic [AW-1:0]                      mem_waddr,
	output logic signed [lal_pkg::VALUE_W-1:0] mem_wdata,
	output logic                               mem_re,
	output logic [AW-1:0]                      mem_raddr,
	input  logic signed [lal_pkg::VALUE_W-1:0] mem_rdata
);

	localparam int CMP_W = LW + lal_pkg::POS_W;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SHIFT = 6'b000010,
		S_DRAIN = 6'b000100,
		S_PLACE = 6'b001000,
		S_SCAN  = 6'b010000,
		S_CHECK = 6'b100000
	} state_t;

	state_t                             state_q;
	logic [LW-1:0]                      len_q;
	logic [AW-1:0]                      rd_addr_q;
	logic [AW-1:0]                      pos_q;
	logic signed [lal_pkg::VALUE_W-1:0] value_q;
	logic                               hit_q;
	logic                               done_q;
	lal_pkg::status_t                   status_q;
	logic                               found_q;
	logic [LW-1:0]                      count_len_q;

	logic                               rvld_s1;
	logic [AW-1:0]                      raddr_s1;

	logic                               accept;
	logic [CMP_W-1:0]                   pos_ext;
	logic [CMP_W-1:0]                   len_ext;
	logic [LW-1:0]                      len_m1;
	logic [LW-1:0]                      len_p1;
	logic                               match;
	logic [CMP_W-1:0]                   cnt_ext;

	assign accept  = start && (state_q == S_IDLE);
	assign pos_ext = {{LW{1'b0}}, position};
	assign len_ext = {{lal_pkg::POS_W{1'b0}}, len_q};
	assign len_m1  = len_q - LW'(1);
	assign len_p1  = len_q + LW'(1);
	assign match   = (mem_rdata == value_q);

	// Reads run one address ahead of the write-back, so the shift reads entry r-2
	// while writing entry r: the two never touch the same entry in one cycle.
	assign mem_re    = (state_q == S_SHIFT) || (state_q == S_SCAN);
	assign mem_raddr = rd_addr_q;
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = raddr_s1 + AW'(1);
		mem_wdata = mem_rdata;
		case (state_q)
			S_SHIFT, S_DRAIN: begin
				mem_we = rvld_s1;
			end
			S_PLACE: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q;
				mem_wdata = value_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_s1 <= 1'b0;
		end else begin
			rvld_s1 <= mem_re;
		end
	end

	always_ff @(posedge clk) begin
		raddr_s1 <= rd_addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (func == lal_pkg::FUNC_SEARCH) begin
							if (len_q == '0) begin
								done_q <= 1'b1;
							end else begin
								state_q <= S_SCAN;
							end
						end else if (pos_ext > len_ext) begin
							done_q <= 1'b1;
						end else if (len_q == LW'(SLOTS)) begin
							done_q <= 1'b1;
						end else if (value == lal_pkg::RESERVED_VALUE) begin
							done_q <= 1'b1;
						end else if (pos_ext == len_ext) begin
							state_q <= S_PLACE;
						end else begin
							state_q <= S_SHIFT;
						end
					end
				end
				S_SHIFT: begin
					if (rd_addr_q == pos_q) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_PLACE;
				end
				S_PLACE: begin
					len_q   <= len_p1;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (rd_addr_q == len_m1[AW-1:0]) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Operand, address and result registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					value_q     <= value;
					pos_q       <= pos_ext[AW-1:0];
					hit_q       <= 1'b0;
					found_q     <= 1'b0;
					count_len_q <= len_q;
					status_q    <= lal_pkg::STAT_OK;
					if (func == lal_pkg::FUNC_SEARCH) begin
						rd_addr_q <= '0;
					end else begin
						rd_addr_q <= len_m1[AW-1:0];
						if (pos_ext > len_ext) begin
							status_q <= lal_pkg::STAT_BAD_POS;
						end else if (len_q == LW'(SLOTS)) begin
							status_q <= lal_pkg::STAT_FULL;
						end else if (value == lal_pkg::RESERVED_VALUE) begin
							status_q <= lal_pkg::STAT_RESERVED;
						end
					end
				end
			end
			S_SHIFT: begin
				rd_addr_q <= rd_addr_q - AW'(1);
			end
			S_PLACE: begin
				count_len_q <= len_p1;
			end
			S_SCAN: begin
				rd_addr_q <= rd_addr_q + AW'(1);
				if (rvld_s1 && match) begin
					hit_q <= 1'b1;
				end
			end
			S_CHECK: begin
				found_q <= hit_q || match;
			end
			default: begin
				hit_q <= hit_q;
			end
		endcase
	end

	assign cnt_ext = {{lal_pkg::POS_W{1'b0}}, count_len_q};
	assign busy    = (state_q != S_IDLE);
	assign done    = done_q;
	assign status  = status_q;
	assign found   = found_q;
	assign count   = cnt_ext[lal_pkg::COUNT_W-1:0];

	`ASSERT_IMP(a_done_idle, clk, arst_n, done_q, state_q == S_IDLE,
		"result strobe while an operation is still running")
	`ASSERT_IMP(a_write_insert, clk, arst_n, mem_we,
		(state_q == S_SHIFT) || (state_q == S_DRAIN) || (state_q == S_PLACE),
		"store written outside an insert")
	`ASSERT_IMP(a_len_bound, clk, arst_n, 1'b1, len_q <= LW'(SLOTS),
		"list length beyond capacity")
	`ASSERT_NEXT(a_bad_pos, clk, arst_n,
		accept && (func == lal_pkg::FUNC_INSERT) && (pos_ext > len_ext),
		done_q && (status_q == lal_pkg::STAT_BAD_POS),
		"insert past the end not rejected")
	`ASSERT_NEXT(a_len_hold, clk, arst_n, state_q != S_PLACE, len_q == $past(len_q),
		"list length changed outside the place step")

endmodule

// ===== src/array_list_insert_search.sv =====
// Channel   Handshake            Word fields
// -------   ------------------   --------------------------------
// command   start / busy         func, value, position
// result    done (1-cycle)       status, found, count
//
// A command is taken at a rising edge with start high and busy low.
// A rejected insert or a search of an empty list answers in the next cycle.
// An append goes straight to the place step; an insert that moves k entries
// does one store read per moved entry, then one drain of the read, then the place.
// A search of a list of n entries does one read per entry, then one compare.
// Reset clears the length, so the list starts empty; no clearing pass is needed.
// The done strobe lasts one cycle and cannot be held off by the receiver.
module array_list_insert_search #(
	parameter int CAPACITY = 128
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               func,
	input  logic signed [lal_pkg::VALUE_W-1:0] value,
	input  logic [lal_pkg::POS_W-1:0]          position,
	output logic                               done,
	output logic [1:0]                         status,
	output logic                               found,
	output logic [lal_pkg::COUNT_W-1:0]        count
);

	// The list holds one entry fewer than the capacity.
	localparam int SLOTS = CAPACITY - 1;
	// Address width of the store, and width of the length register.
	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LW = $clog2(CAPACITY);

	logic                               mem_we;
	logic [AW-1:0]                      mem_waddr;
	logic signed [lal_pkg::VALUE_W-1:0] mem_wdata;
	logic                               mem_re;
	logic [AW-1:0]                      mem_raddr;
	logic signed [lal_pkg::VALUE_W-1:0] mem_rdata;

	// Sequencer: decodes each word, runs the shift or the scan, holds the length.
	lal_seq #(
		.SLOTS(SLOTS),
		.AW   (AW),
		.LW   (LW)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.func     (func),
		.value    (value),
		.position (position),
		.done     (done),
		.status   (status),
		.found    (found),
		.count    (count),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	// List storage with a registered read.
	lal_store #(
		.DEPTH(SLOTS),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule

// ===== bench/list_monitor.sv =====
`timescale 1ns / 1ps

// Watches the command and result channels, keeps a shadow copy of the list
// and compares every result word with the oldest outstanding prediction.
module list_monitor
	import lal_pkg::*;
#(
	parameter int CAPACITY = 128
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  logic                      func,
	input  logic signed [VALUE_W-1:0] value,
	input  logic [POS_W-1:0]          position,
	input  logic                      done,
	input  logic [1:0]                status,
	input  logic                      found,
	input  logic [COUNT_W-1:0]        count,
	output int                        errors,
	output int                        pending
);

	localparam int SLOTS = CAPACITY - 1;

	typedef struct {
		status_t            st;
		logic               hit;
		logic [COUNT_W-1:0] len;
	} reply_t;

	reply_t                    predicted_replies[$];
	logic signed [VALUE_W-1:0] shadow_list[SLOTS];
	int                        shadow_len;
	int                        n_err;

	always @(posedge clk or negedge arst_n) begin : track
		reply_t want;
		int     i;
		if (!arst_n) begin
			shadow_len = 0;
			n_err = 0;
			predicted_replies.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			// Results are retired before a new command is taken, so a word that
			// finishes in the same cycle as the next acceptance lines up correctly.
			if (done) begin
				if (predicted_replies.size() == 0) begin
					$display("%0t: unexpected result, status %0d found %0d count %0d",
						$time, status, found, count);
					n_err++;
				end else begin
					want = predicted_replies.pop_front();
					if (status !== want.st) begin
						$display("%0t: status expected %0d, actual %0d", $time, want.st, status);
						n_err++;
					end
					if (found !== want.hit) begin
						$display("%0t: found expected %0d, actual %0d", $time, want.hit, found);
						n_err++;
					end
					if (count !== want.len) begin
						$display("%0t: count expected %0d, actual %0d", $time, want.len, count);
						n_err++;
					end
				end
			end
			if (start && !busy) begin
				want.st = STAT_OK;
				want.hit = 1'b0;
				if (func == FUNC_INSERT) begin
					if (int'(position) > shadow_len) begin
						want.st = STAT_BAD_POS;
					end else if (shadow_len >= SLOTS) begin
						want.st = STAT_FULL;
					end else if (value == RESERVED_VALUE) begin
						want.st = STAT_RESERVED;
					end else begin
						for (i = shadow_len; i > int'(position); i--)
							shadow_list[i] = shadow_list[i - 1];
						shadow_list[position] = value;
						shadow_len++;
					end
				end else begin
					for (i = 0; i < shadow_len; i++)
						if (shadow_list[i] == value)
							want.hit = 1'b1;
				end
				want.len = shadow_len[COUNT_W-1:0];
				predicted_replies.push_back(want);
			end
			errors <= n_err;
			pending <= predicted_replies.size();
		end
	end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

// Top of the bench for the array list block. It builds the command stream,
// while list_monitor predicts and checks every result word. The verdict is
// given here from the monitor's error count.
module tb;
	import lal_pkg::*;

	localparam int CAPACITY = 128;
	localparam int SLOTS    = CAPACITY - 1;
	// The slowest word is a search of a full list, plus the longest sender
	// gap between bursts. A few hundred words stay far below this limit,
	// so it leaves a wide margin.
	localparam int LIMIT = 500000;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      start = 1'b0;
	logic                      busy;
	logic                      func = FUNC_INSERT;
	logic signed [VALUE_W-1:0] value = '0;
	logic [POS_W-1:0]          position = '0;
	logic                      done;
	logic [1:0]                status;
	logic                      found;
	logic [COUNT_W-1:0]        count;
	int                        errors;
	int                        pending;
	int                        cycles = 0;

	// Stimulus-side bookkeeping. It only shapes the stream (which positions
	// are legal, which values are worth searching for); checking is done by
	// the monitor.
	int                        burst_left = 0;
	int                        fill = 0;
	logic signed [VALUE_W-1:0] stored_values[$];

	always #2 clk = ~clk;

	array_list_insert_search #(
		.CAPACITY(CAPACITY)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.func    (func),
		.value   (value),
		.position(position),
		.done    (done),
		.status  (status),
		.found   (found),
		.count   (count)
	);

	list_monitor #(
		.CAPACITY(CAPACITY)
	) u_monitor (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.func    (func),
		.value   (value),
		.position(position),
		.done    (done),
		.status  (status),
		.found   (found),
		.count   (count),
		.errors  (errors),
		.pending (pending)
	);

	// Hard stop in case the block hangs or stops answering.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Presents one command word and returns at the edge that accepts it.
	// The sender works in bursts: when a burst runs out, start drops for a
	// random gap, and sometimes the next burst follows with no gap at all.
	// Start stays high between words of a burst, so it is never lowered and
	// raised in the same time step.
	task automatic issue_word(input logic f, input logic signed [VALUE_W-1:0] v,
		input logic [POS_W-1:0] p);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		start <= 1'b1;
		func <= f;
		value <= v;
		position <= p;
		do @(posedge clk); while (busy);
		burst_left--;
		// Track the length the list should have, so later positions can be
		// chosen inside or just outside the valid range.
		if (f == FUNC_INSERT && int'(p) <= fill && fill < SLOTS && v != RESERVED_VALUE) begin
			fill++;
			stored_values.push_back(v);
		end
	endtask

	// Stops sending and waits until every predicted result has arrived.
	// The monitor updates its count at the rising edge, so it is read at the
	// falling edge to stay clear of that update.
	task automatic drain_replies();
		start <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
		burst_left = 0;
	endtask

	// Small values so that duplicates and search hits happen, the most negative
	// value, the largest one below the reserved value, and, most often, fully random words.
	function automatic logic signed [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7FFF_FFFE;
			2, 3:    return 32'($urandom_range(0, 16)) - 32'sd8;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int n;
		int pick;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. An empty list first: a search finds nothing, and an
		// insert past the end is rejected even at the largest position.
		issue_word(FUNC_SEARCH, 32'sd0, 7'd0);
		issue_word(FUNC_INSERT, 32'sd5, 7'd1);
		issue_word(FUNC_INSERT, 32'sd5, 7'd127);
		// The reserved value is refused at a legal position; at an illegal
		// position the position check wins.
		issue_word(FUNC_INSERT, RESERVED_VALUE, 7'd0);
		issue_word(FUNC_INSERT, RESERVED_VALUE, 7'd100);
		// Build a short list: most negative value, an append, an insert at the head that
		// moves two entries, one in the middle, an insert past the end and a final append.
		issue_word(FUNC_INSERT, 32'sh8000_0000, 7'd0);
		issue_word(FUNC_INSERT, -32'sd1, 7'd1);
		issue_word(FUNC_INSERT, 32'sd0, 7'd0);
		issue_word(FUNC_INSERT, 32'sh7FFF_FFFE, 7'd1);
		issue_word(FUNC_INSERT, 32'sd3, 7'd5);
		issue_word(FUNC_INSERT, 32'sd12345, 7'd4);
		// Searches: hits at every spot, a miss, and the reserved value, which
		// is never found. The position field is ignored here.
		issue_word(FUNC_SEARCH, 32'sh8000_0000, 7'd127);
		issue_word(FUNC_SEARCH, -32'sd1, 7'd0);
		issue_word(FUNC_SEARCH, 32'sh7FFF_FFFE, 7'd64);
		issue_word(FUNC_SEARCH, RESERVED_VALUE, 7'd0);
		issue_word(FUNC_SEARCH, 32'sd42, 7'd0);
		issue_word(FUNC_SEARCH, 32'sd12345, 7'd3);
		issue_word(FUNC_SEARCH, 32'sd0, 7'd0);
		// Let the pipeline run dry once before the random part.
		drain_replies();

		// Random part. Most words are legal inserts with random content, so
		// the list fills up to its capacity; after that the inserts hit the
		// full-list check. Searches pick stored values most of the time.
		for (n = 0; n < 400; n++) begin
			if (n == 150)
				drain_replies();
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				if (fill < SLOTS)
					issue_word(FUNC_INSERT, pick_value(), 7'($urandom_range(0, fill)));
				else
					issue_word(FUNC_INSERT, pick_value(), 7'($urandom_range(0, 127)));
			end else if (pick < 63) begin
				// Broken inserts: past the end, or the reserved value.
				if (fill < SLOTS && $urandom_range(0, 1) == 0)
					issue_word(FUNC_INSERT, pick_value(), 7'($urandom_range(fill + 1, 127)));
				else
					issue_word(FUNC_INSERT, RESERVED_VALUE, 7'($urandom_range(0, fill)));
			end else begin
				if (stored_values.size() > 0 && $urandom_range(0, 9) < 6)
					issue_word(FUNC_SEARCH,
						stored_values[$urandom_range(0, stored_values.size() - 1)],
						7'($urandom_range(0, 127)));
				else
					issue_word(FUNC_SEARCH, pick_value(), 7'($urandom_range(0, 127)));
			end
		end

		// Wait for the last results, then keep the clock running to catch any
		// stray strobe.
		drain_replies();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/lal_pkg.sv
src/lal_store.sv
src/lal_seq.sv
src/array_list_insert_search.sv
bench/list_monitor.sv
bench/tb.sv
